// ===== rtl/core/mhrm_pkg.sv =====
// ----------------------------------------------------------------------------
// MMC host register model package
// Register indexes, command codes, card response words and the beat and
// write-port types shared by the register model modules.
// ----------------------------------------------------------------------------
package mhrm_pkg;

    localparam int IDX_W   = 7;
    localparam int DATA_W  = 32;
    localparam int CODE_W  = 6;
    localparam int OFS_W   = 10;
    localparam int BLKC_W  = 16;
    localparam int BLK_SHIFT = 7;   // 128 words per block

    // Access kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Register map (word index)
    localparam logic [IDX_W-1:0] IDX_CMD  = 7'd0;
    localparam logic [IDX_W-1:0] IDX_ARG  = 7'd1;
    localparam logic [IDX_W-1:0] IDX_RSP0 = 7'd4;
    localparam logic [IDX_W-1:0] IDX_RSP1 = 7'd5;
    localparam logic [IDX_W-1:0] IDX_RSP2 = 7'd6;
    localparam logic [IDX_W-1:0] IDX_RSP3 = 7'd7;
    localparam logic [IDX_W-1:0] IDX_DATA = 7'd16;

    // MMC command codes
    localparam logic [CODE_W-1:0] CMD_SEND_OP_COND    = 6'd1;
    localparam logic [CODE_W-1:0] CMD_ALL_SEND_CID    = 6'd2;
    localparam logic [CODE_W-1:0] CMD_SEND_EXT_CSD    = 6'd8;
    localparam logic [CODE_W-1:0] CMD_SEND_CSD        = 6'd9;
    localparam logic [CODE_W-1:0] CMD_SEND_STATUS     = 6'd13;
    localparam logic [CODE_W-1:0] CMD_READ_MULTIPLE   = 6'd18;
    localparam logic [CODE_W-1:0] CMD_SET_BLOCK_COUNT = 6'd23;
    localparam logic [CODE_W-1:0] CMD_WRITE_MULTIPLE  = 6'd25;

    // Card responses
    localparam logic [DATA_W-1:0] RSP_OP_COND = 32'h80ff_8000;
    localparam logic [DATA_W-1:0] RSP_CID0    = 32'h0000_0001;
    localparam logic [DATA_W-1:0] RSP_CID3    = 32'h1500_0000;
    localparam logic [DATA_W-1:0] RSP_CSD0    = 32'h9240_4001;
    localparam logic [DATA_W-1:0] RSP_CSD1    = 32'hd24b_97e3;  // C_SIZE low bits merged
    localparam logic [DATA_W-1:0] RSP_CSD2    = 32'h0f5f_80ff;  // C_SIZE high, block length code 15
    localparam logic [DATA_W-1:0] RSP_CSD3    = 32'h9026_012a;

    // EXT_CSD read-out
    localparam logic [OFS_W-1:0]  EXT_OFS_STEP      = 10'd4;
    localparam logic [OFS_W-1:0]  EXT_OFS_CARD_TYPE = 10'd192;
    localparam logic [OFS_W-1:0]  EXT_OFS_SECTORS   = 10'd212;
    localparam logic [OFS_W-1:0]  EXT_OFS_LAST      = 10'd508;
    localparam logic [DATA_W-1:0] EXT_CARD_TYPE_VAL = 32'd2;
    localparam logic [DATA_W-1:0] EXT_SECTORS_VAL   = 32'h0200_0000;

    // One bus access
    typedef struct packed {
        logic              wr;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] wdata;
    } acc_t;

    // Write into the plain register store
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] data;
    } reg_wr_t;

endpackage

// ===== rtl/core/mmc_host_register_model.sv =====
// ----------------------------------------------------------------------------
// MMC host register model
// Word-addressed register file of a polled MMC host with an attached card
// image store.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one bus access per beat. s_tuser[0] is the access kind
//   (0 read, 1 write); s_tdata holds the word index and the write word.
//   m_ channel: one beat per access, carrying the register contents after
//   the access (also on writes; zero for an index beyond the file).
//   Result path: a taken access beat goes into the input register, then is
//   executed into the output register, which holds the result beat.
//   Throughput: one access per cycle unless stalled. The card store and the
//   plain register store are read when the access is taken, using the transfer
//   pointer as left by the access ahead of it, and are written on execute.
//   Reset: the register file and transfer state clear at once; the card store is
//   then swept to zero word by word, with s_tready low throughout.
//   Stall: while m_tready is low the result beat holds, one further access
//   is held in the input register, and s_tready drops after that.
//   CARD_WORDS must be a power of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module mmc_host_register_model #(
    parameter int CARD_WORDS = 65536,
    parameter int REG_WORDS  = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // reg_index[6:0], write_data[38:7], zero pad
    input  logic [0:0]  s_tuser,    // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // read_data[31:0]
);

    localparam int CARD_AW = $clog2(CARD_WORDS);
    localparam int REG_AW  = $clog2(REG_WORDS);

    logic                 clr_busy_reg;
    logic [CARD_AW-1:0]   clr_addr_reg;
    logic                 acc_valid_reg;
    mhrm_pkg::acc_t       acc_reg;
    logic                 m_valid_reg;
    logic [31:0]          m_data_reg;
    logic                 byp_reg;
    logic [31:0]          byp_data_reg;
    logic [REG_WORDS-1:0] plain_valid_reg;

    logic                 exec_go;
    logic                 s_accept;
    mhrm_pkg::acc_t       in_acc;
    logic                 byp_hit;
    logic [31:0]          reg_q;
    logic [31:0]          plain_q;
    logic [31:0]          card_q;
    logic [31:0]          result;
    mhrm_pkg::reg_wr_t    reg_wr;
    logic                 core_card_we;
    logic [CARD_AW-1:0]   core_card_waddr;
    logic [31:0]          core_card_wdata;
    logic [CARD_AW-1:0]   card_ptr_next;
    logic                 card_we;
    logic [CARD_AW-1:0]   card_waddr;
    logic [31:0]          card_wdata;

    // Handshake
    assign exec_go  = acc_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_busy_reg && (!acc_valid_reg || exec_go);
    assign s_accept = s_tvalid && s_tready;

    assign in_acc.wr    = s_tuser[0];
    assign in_acc.idx   = s_tdata[6:0];
    assign in_acc.wdata = s_tdata[38:7];

    // Catch a plain-register write landing on the address being read
    assign byp_hit = reg_wr.en && (reg_wr.idx == in_acc.idx);

    // Clearing sweep of the card store after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + CARD_AW'(1);
            if (clr_addr_reg == CARD_AW'(CARD_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Input register and read bypass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_valid_reg <= 1'b0;
        end else if (s_accept) begin
            acc_valid_reg <= 1'b1;
        end else if (exec_go) begin
            acc_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            acc_reg      <= in_acc;
            byp_reg      <= byp_hit;
            byp_data_reg <= reg_wr.data;
        end
    end

    // Written marks of the plain register store; unwritten entries read zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plain_valid_reg <= '0;
        end else if (reg_wr.en) begin
            plain_valid_reg[reg_wr.idx[REG_AW-1:0]] <= 1'b1;
        end
    end

    assign plain_q = byp_reg ? byp_data_reg :
                     (plain_valid_reg[acc_reg.idx[REG_AW-1:0]] ? reg_q : '0);

    mhrm_ram #(
        .WIDTH (32),
        .DEPTH (REG_WORDS)
    ) u_reg_ram (
        .aclk  (aclk),
        .we    (reg_wr.en),
        .waddr (reg_wr.idx[REG_AW-1:0]),
        .wdata (reg_wr.data),
        .re    (s_accept),
        .raddr (in_acc.idx[REG_AW-1:0]),
        .rdata (reg_q)
    );

    // Card store: sweep writes during the clearing pass, data port afterwards
    assign card_we    = clr_busy_reg || core_card_we;
    assign card_waddr = clr_busy_reg ? clr_addr_reg : core_card_waddr;
    assign card_wdata = clr_busy_reg ? '0 : core_card_wdata;

    mhrm_ram #(
        .WIDTH (32),
        .DEPTH (CARD_WORDS)
    ) u_card_ram (
        .aclk  (aclk),
        .we    (card_we),
        .waddr (card_waddr),
        .wdata (card_wdata),
        .re    (s_accept),
        .raddr (card_ptr_next),
        .rdata (card_q)
    );

    mhrm_core #(
        .CARD_WORDS (CARD_WORDS),
        .REG_WORDS  (REG_WORDS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .exec_go       (exec_go),
        .acc           (acc_reg),
        .plain_q       (plain_q),
        .card_q        (card_q),
        .result        (result),
        .reg_wr        (reg_wr),
        .card_we       (core_card_we),
        .card_waddr    (core_card_waddr),
        .card_wdata    (core_card_wdata),
        .card_ptr_next (card_ptr_next)
    );

    // Output register: load on execute, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_go) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/mhrm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, registered read, read-first on a
// same-address collision.
// ----------------------------------------------------------------------------
module mhrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mhrm_core.sv =====
// ----------------------------------------------------------------------------
// MMC host register model execute unit
// Holds the command, argument, response and data registers and the card
// transfer state, and executes one access per cycle while exec_go is high.
// ----------------------------------------------------------------------------
module mhrm_core #(
    parameter int CARD_WORDS = 65536,
    parameter int REG_WORDS  = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          exec_go,
    input  mhrm_pkg::acc_t                acc,
    input  logic [mhrm_pkg::DATA_W-1:0]   plain_q,
    input  logic [mhrm_pkg::DATA_W-1:0]   card_q,
    output logic [mhrm_pkg::DATA_W-1:0]   result,
    output mhrm_pkg::reg_wr_t             reg_wr,
    output logic                          card_we,
    output logic [$clog2(CARD_WORDS)-1:0] card_waddr,
    output logic [mhrm_pkg::DATA_W-1:0]   card_wdata,
    output logic [$clog2(CARD_WORDS)-1:0] card_ptr_next
);

    localparam int CARD_AW = $clog2(CARD_WORDS);
    localparam int ARGX_W  = mhrm_pkg::DATA_W + mhrm_pkg::BLK_SHIFT;

    logic [mhrm_pkg::DATA_W-1:0] cmd_reg, cmd_next;
    logic [mhrm_pkg::DATA_W-1:0] arg_reg, arg_next;
    logic [mhrm_pkg::DATA_W-1:0] rsp_reg [4];
    logic [mhrm_pkg::DATA_W-1:0] rsp_next [4];
    logic [mhrm_pkg::DATA_W-1:0] data_reg, data_next;
    logic [CARD_AW-1:0]          ptr_reg, ptr_next;
    logic                        ext_active_reg, ext_active_next;
    logic [mhrm_pkg::OFS_W-1:0]  ext_ofs_reg, ext_ofs_next;
    logic                        wr_mode_reg, wr_mode_next;
    logic [mhrm_pkg::BLKC_W-1:0] blk_cnt_reg, blk_cnt_next;

    logic              in_range;
    logic              is_wr;
    logic [ARGX_W-1:0] arg_x128;

    assign in_range = {1'b0, acc.idx} < 8'(REG_WORDS);
    assign is_wr    = in_range && (acc.wr == mhrm_pkg::REQ_WRITE);
    assign arg_x128 = {arg_reg, {mhrm_pkg::BLK_SHIFT{1'b0}}};

    // Execute: store the written word, then act on command or data port
    always_comb begin
        cmd_next        = cmd_reg;
        arg_next        = arg_reg;
        rsp_next        = rsp_reg;
        data_next       = data_reg;
        ptr_next        = ptr_reg;
        ext_active_next = ext_active_reg;
        ext_ofs_next    = ext_ofs_reg;
        wr_mode_next    = wr_mode_reg;
        blk_cnt_next    = blk_cnt_reg;
        reg_wr          = '0;
        card_we         = 1'b0;
        card_waddr      = ptr_reg;
        card_wdata      = data_reg;

        if (exec_go && in_range) begin
            // store the written word
            if (is_wr) begin
                case (acc.idx) inside
                    mhrm_pkg::IDX_CMD:  cmd_next  = acc.wdata;
                    mhrm_pkg::IDX_ARG:  arg_next  = acc.wdata;
                    mhrm_pkg::IDX_RSP0, mhrm_pkg::IDX_RSP1,
                    mhrm_pkg::IDX_RSP2, mhrm_pkg::IDX_RSP3:
                        rsp_next[acc.idx[1:0]] = acc.wdata;
                    mhrm_pkg::IDX_DATA: data_next = acc.wdata;
                    default: begin
                        reg_wr.en   = 1'b1;
                        reg_wr.idx  = acc.idx;
                        reg_wr.data = acc.wdata;
                    end
                endcase
            end

            // run the command in the low six bits
            if (acc.idx == mhrm_pkg::IDX_CMD) begin
                unique case (cmd_next[mhrm_pkg::CODE_W-1:0])
                    mhrm_pkg::CMD_SEND_OP_COND: begin
                        rsp_next[0] = mhrm_pkg::RSP_OP_COND;
                    end
                    mhrm_pkg::CMD_ALL_SEND_CID: begin
                        rsp_next[0] = mhrm_pkg::RSP_CID0;
                        rsp_next[1] = '0;
                        rsp_next[2] = '0;
                        rsp_next[3] = mhrm_pkg::RSP_CID3;
                    end
                    mhrm_pkg::CMD_SEND_EXT_CSD: begin
                        ext_active_next = 1'b1;
                        ext_ofs_next    = '0;
                    end
                    mhrm_pkg::CMD_SEND_CSD: begin
                        rsp_next[0] = mhrm_pkg::RSP_CSD0;
                        rsp_next[1] = mhrm_pkg::RSP_CSD1;
                        rsp_next[2] = mhrm_pkg::RSP_CSD2;
                        rsp_next[3] = mhrm_pkg::RSP_CSD3;
                    end
                    mhrm_pkg::CMD_SEND_STATUS: begin
                        rsp_next[0] = '0;
                        rsp_next[1] = '0;
                        rsp_next[2] = '0;
                        rsp_next[3] = '0;
                    end
                    mhrm_pkg::CMD_READ_MULTIPLE: begin
                        ptr_next     = arg_x128[CARD_AW-1:0];
                        ext_ofs_next = '0;
                        wr_mode_next = 1'b0;
                    end
                    mhrm_pkg::CMD_SET_BLOCK_COUNT: begin
                        blk_cnt_next = arg_reg[mhrm_pkg::BLKC_W-1:0];
                    end
                    mhrm_pkg::CMD_WRITE_MULTIPLE: begin
                        ptr_next     = arg_x128[CARD_AW-1:0];
                        ext_ofs_next = '0;
                        wr_mode_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end

            // move one word through the data port
            if (acc.idx == mhrm_pkg::IDX_DATA) begin
                if (ext_active_reg) begin
                    if (ext_ofs_reg == mhrm_pkg::EXT_OFS_CARD_TYPE) begin
                        data_next = mhrm_pkg::EXT_CARD_TYPE_VAL;
                    end else if (ext_ofs_reg == mhrm_pkg::EXT_OFS_SECTORS) begin
                        data_next = mhrm_pkg::EXT_SECTORS_VAL;
                    end else begin
                        data_next = '0;
                    end
                    if (ext_ofs_reg == mhrm_pkg::EXT_OFS_LAST) begin
                        ext_active_next = 1'b0;
                    end
                end else begin
                    if (wr_mode_reg) begin
                        card_we    = 1'b1;
                        card_wdata = data_next;
                    end else begin
                        data_next = card_q;
                    end
                    ptr_next = ptr_reg + CARD_AW'(1);
                end
                ext_ofs_next = ext_ofs_reg + mhrm_pkg::EXT_OFS_STEP;
            end
        end
    end

    // Return the register after the access
    always_comb begin
        case (acc.idx) inside
            mhrm_pkg::IDX_CMD:  result = cmd_next;
            mhrm_pkg::IDX_ARG:  result = arg_next;
            mhrm_pkg::IDX_RSP0, mhrm_pkg::IDX_RSP1,
            mhrm_pkg::IDX_RSP2, mhrm_pkg::IDX_RSP3:
                result = rsp_next[acc.idx[1:0]];
            mhrm_pkg::IDX_DATA: result = data_next;
            default:            result = is_wr ? acc.wdata : plain_q;
        endcase
        if (!in_range) begin
            result = '0;
        end
    end

    assign card_ptr_next = ptr_next;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg        <= '0;
            arg_reg        <= '0;
            rsp_reg        <= '{default: '0};
            data_reg       <= '0;
            ptr_reg        <= '0;
            ext_active_reg <= 1'b0;
            ext_ofs_reg    <= '0;
            wr_mode_reg    <= 1'b0;
            blk_cnt_reg    <= '0;
        end else begin
            cmd_reg        <= cmd_next;
            arg_reg        <= arg_next;
            rsp_reg        <= rsp_next;
            data_reg       <= data_next;
            ptr_reg        <= ptr_next;
            ext_active_reg <= ext_active_next;
            ext_ofs_reg    <= ext_ofs_next;
            wr_mode_reg    <= wr_mode_next;
            blk_cnt_reg    <= blk_cnt_next;
        end
    end

endmodule
